@@ rtl/core/wtsp_pkg.sv @@
// Package for world_to_screen_projection: shared widths, codes and reset values.
// No dependencies.
`default_nettype none
package wtsp_pkg;
    localparam int DATA_W        = 32;
    localparam int DIM_W         = 14;
    localparam int IDX_W         = 4;
    localparam int ADDR_W        = 3;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_PROJECT = 1'b1;

    localparam logic [ADDR_W-1:0] ADDR_WIDTH  = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_HEIGHT = 3'd4;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd480;
endpackage
`default_nettype wire

@@ rtl/core/world_to_screen_projection.sv @@
// world_to_screen_projection: load/project item stream to screen pixel coordinates.
// Uses wtsp_pkg. Single module: multiply, clip sum, bit-per-stage divider, viewport map.
//
// Usage:
//   Input channel (in_valid/in_stall) carries items. A load item (req_type 0) writes
//   coefficient coef_index of the column-major 4x4 matrix; it gives no result.
//   A project item (req_type 1) gives one result on the output channel
//   (out_valid/out_stall): visible, screen_x, screen_y in signed fixed point.
//   Matrix coefficients must be loaded before they are used.
//   Coordinates are Q16.16 at the default FRAC_BITS.
//   The long divider resolves one quotient bit per stage for X and Y.
//   Throughput: one item per cycle while the output is not stalled.
//   The pipeline moves as a whole; when the output is stalled with a result
//   waiting, in_stall rises and every stage holds. Nothing is lost or repeated.
//   Reset clears all valid bits and sets width 640, height 480. The APB port
//   writes width at 0x0 and height at 0x4; pready is always high.
`default_nettype none
module world_to_screen_projection #(
    parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [wtsp_pkg::ADDR_W-1:0]            paddr,
    input  wire logic [31:0]                            pwdata,
    output logic      [31:0]                            prdata,
    output logic                                        pready,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic                                   req_type,
    input  wire logic [wtsp_pkg::IDX_W-1:0]             coef_index,
    input  wire logic signed [wtsp_pkg::DATA_W-1:0]     coef_value,
    input  wire logic signed [wtsp_pkg::DATA_W-1:0]     pos_x,
    input  wire logic signed [wtsp_pkg::DATA_W-1:0]     pos_y,
    input  wire logic signed [wtsp_pkg::DATA_W-1:0]     pos_z,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        visible,
    output logic signed [wtsp_pkg::DATA_W-1:0]          screen_x,
    output logic signed [wtsp_pkg::DATA_W-1:0]          screen_y
);
    localparam int DW    = wtsp_pkg::DATA_W;
    localparam int PW    = 2 * DW;
    localparam int NW    = DW + FRAC_BITS;
    localparam int SW    = wtsp_pkg::DIM_W + 1 + DW + 2;
    localparam longint ONE   = longint'(1) << FRAC_BITS;
    localparam longint TENTH = (ONE + 5) / 10;
    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] TENTH_C = DW'(TENTH);
    localparam logic signed [DW+1:0] ONE_C   = (DW+2)'(ONE);

    logic en;
    logic [wtsp_pkg::DIM_W-1:0] width_reg, height_reg;
    logic signed [DW-1:0] mat_reg [16];

    assign pready   = 1'b1;
    assign in_stall = out_valid && out_stall;
    assign en       = !in_stall;

    always_comb
    begin
        prdata = '0;
        if (paddr == wtsp_pkg::ADDR_WIDTH)
            prdata = {{(32-wtsp_pkg::DIM_W){1'b0}}, width_reg};
        else if (paddr == wtsp_pkg::ADDR_HEIGHT)
            prdata = {{(32-wtsp_pkg::DIM_W){1'b0}}, height_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= wtsp_pkg::WIDTH_RST;
            height_reg <= wtsp_pkg::HEIGHT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == wtsp_pkg::ADDR_WIDTH)
                width_reg <= pwdata[wtsp_pkg::DIM_W-1:0];
            else if (paddr == wtsp_pkg::ADDR_HEIGHT)
                height_reg <= pwdata[wtsp_pkg::DIM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && en && req_type == wtsp_pkg::REQ_LOAD)
            mat_reg[coef_index] <= coef_value;
    end

    // stage 1: point
    logic s1_valid_reg;
    logic signed [DW-1:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    // stage 2: products (lane 0 x, 1 y, 2 w)
    logic s2_valid_reg;
    logic signed [PW-1:0] s2_prod_reg [3][3];
    logic signed [DW-1:0] s2_off_reg [3];
    // stage 3: clip values
    logic s3_valid_reg;
    logic signed [DW-1:0] s3_clip_reg [3];
    // divider
    logic              dv_valid_reg [NW+1];
    logic              dv_vis_reg   [NW+1];
    logic [DW-2:0]     dv_den_reg   [NW+1];
    logic [DW-1:0]     dv_rem_reg   [NW+1][2];
    logic [NW-1:0]     dv_nq_reg    [NW+1][2];
    logic              dv_neg_reg   [NW+1][2];
    // ndc, products, output
    logic s5_valid_reg, s5_vis_reg;
    logic signed [DW-1:0] s5_ndc_reg [2];
    logic s6_valid_reg, s6_vis_reg;
    logic signed [SW-1:0] s6_prod_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid && req_type == wtsp_pkg::REQ_PROJECT;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s5_valid_reg <= dv_valid_reg[NW];
            s6_valid_reg <= s5_valid_reg;
            out_valid    <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_px_reg <= pos_x;
            s1_py_reg <= pos_y;
            s1_pz_reg <= pos_z;
        end
    end

    // matrix rows used: x -> 0, y -> 1, w -> 3
    localparam int ROW [3] = '{0, 1, 3};

    logic signed [PW-1:0] s3_sum [3];
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            s3_sum[r] = (s2_prod_reg[r][0] >>> FRAC_BITS) + (s2_prod_reg[r][1] >>> FRAC_BITS)
                      + (s2_prod_reg[r][2] >>> FRAC_BITS) + PW'(s2_off_reg[r]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                s2_prod_reg[r][0] <= PW'(s1_px_reg) * PW'(mat_reg[ROW[r]]);
                s2_prod_reg[r][1] <= PW'(s1_py_reg) * PW'(mat_reg[ROW[r] + 4]);
                s2_prod_reg[r][2] <= PW'(s1_pz_reg) * PW'(mat_reg[ROW[r] + 8]);
                s2_off_reg[r]     <= mat_reg[ROW[r] + 12];
                if (s3_sum[r] > PW'(SMAX))
                    s3_clip_reg[r] <= SMAX;
                else if (s3_sum[r] < PW'(SMIN))
                    s3_clip_reg[r] <= SMIN;
                else
                    s3_clip_reg[r] <= s3_sum[r][DW-1:0];
            end
        end
    end

    // divider entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (en)
            dv_valid_reg[0] <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_vis_reg[0] <= s3_clip_reg[2] >= TENTH_C;
            dv_den_reg[0] <= s3_clip_reg[2][DW-2:0];
            for (int l = 0; l < 2; l++)
            begin
                dv_rem_reg[0][l] <= '0;
                dv_neg_reg[0][l] <= s3_clip_reg[l][DW-1];
                dv_nq_reg[0][l]  <= {(s3_clip_reg[l][DW-1] ? -s3_clip_reg[l] : s3_clip_reg[l]),
                                     {FRAC_BITS{1'b0}}};
            end
        end
    end

    for (genvar k = 0; k < NW; k++)
    begin : g_div
        logic [DW-1:0] t [2];
        logic          ge [2];
        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                t[l]  = {dv_rem_reg[k][l][DW-2:0], dv_nq_reg[k][l][NW-1]};
                ge[l] = t[l] >= {1'b0, dv_den_reg[k]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (en)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_vis_reg[k+1] <= dv_vis_reg[k];
                dv_den_reg[k+1] <= dv_den_reg[k];
                for (int l = 0; l < 2; l++)
                begin
                    dv_neg_reg[k+1][l] <= dv_neg_reg[k][l];
                    dv_rem_reg[k+1][l] <= ge[l] ? t[l] - {1'b0, dv_den_reg[k]} : t[l];
                    dv_nq_reg[k+1][l]  <= {dv_nq_reg[k][l][NW-2:0], ge[l]};
                end
            end
        end
    end

    logic signed [DW+1:0] s6_term [2];
    logic signed [SW-1:0] s7_half [2];
    logic signed [DW-1:0] s7_sat  [2];
    always_comb
    begin
        s6_term[0] = ONE_C + (DW+2)'(s5_ndc_reg[0]);
        s6_term[1] = ONE_C - (DW+2)'(s5_ndc_reg[1]);
        for (int l = 0; l < 2; l++)
        begin
            s7_half[l] = s6_prod_reg[l] >>> 1;
            if (s7_half[l] > SW'(SMAX))
                s7_sat[l] = SMAX;
            else if (s7_half[l] < SW'(SMIN))
                s7_sat[l] = SMIN;
            else
                s7_sat[l] = s7_half[l][DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_vis_reg <= dv_vis_reg[NW];
            for (int l = 0; l < 2; l++)
            begin
                if (dv_neg_reg[NW][l])
                    s5_ndc_reg[l] <= (dv_nq_reg[NW][l] > NW'(longint'(1) << (DW-1)))
                                   ? SMIN : -DW'(dv_nq_reg[NW][l]);
                else
                    s5_ndc_reg[l] <= (dv_nq_reg[NW][l] > NW'(SMAX))
                                   ? SMAX : DW'(dv_nq_reg[NW][l]);
            end
            s6_vis_reg <= s5_vis_reg;
            s6_prod_reg[0] <= SW'($signed({1'b0, width_reg})) * SW'(s6_term[0]);
            s6_prod_reg[1] <= SW'($signed({1'b0, height_reg})) * SW'(s6_term[1]);
            visible  <= s6_vis_reg;
            screen_x <= s6_vis_reg ? s7_sat[0] : '0;
            screen_y <= s6_vis_reg ? s7_sat[1] : '0;
        end
    end
endmodule
`default_nettype wire

@@ test/wtsp_checker.sv @@
// Checker for world_to_screen_projection: watches the APB port and both item channels,
// predicts each projection result in Q16.16 and compares it field by field.
// Depends on wtsp_pkg.
`timescale 1ns / 100ps
`default_nettype none
module wtsp_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic                          pready,
    input  wire logic [wtsp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic                          req_type,
    input  wire logic [wtsp_pkg::IDX_W-1:0]    coef_index,
    input  wire logic signed [31:0]            coef_value,
    input  wire logic signed [31:0]            pos_x,
    input  wire logic signed [31:0]            pos_y,
    input  wire logic signed [31:0]            pos_z,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic                          visible,
    input  wire logic signed [31:0]            screen_x,
    input  wire logic signed [31:0]            screen_y,
    output int                                 errors,
    output int                                 pending,
    output int                                 n_loads,
    output int                                 n_onscreen,
    output int                                 n_offscreen
);
    import wtsp_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint ONE = 64'sd1 <<< FB;
    localparam longint TENTH = (ONE + 5) / 10;

    typedef struct packed {
        logic               vis;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } screen_pt_t;

    logic signed [31:0] coef_mem [16];
    logic [DIM_W-1:0]   vp_width;
    logic [DIM_W-1:0]   vp_height;
    screen_pt_t         expected_pts [$];

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip_sum(int r, longint px, longint py, longint pz);
        longint c0, c1, c2, c3;
        c0 = coef_mem[r];
        c1 = coef_mem[r + 4];
        c2 = coef_mem[r + 8];
        c3 = coef_mem[r + 12];
        return sat32(((px * c0) >>> FB) + ((py * c1) >>> FB) + ((pz * c2) >>> FB) + c3);
    endfunction

    function automatic screen_pt_t project_point(longint px, longint py, longint pz);
        screen_pt_t p;
        longint cx, cy, cw, nx, ny, w, h;
        cx = clip_sum(0, px, py, pz);
        cy = clip_sum(1, px, py, pz);
        cw = clip_sum(3, px, py, pz);
        w = longint'(vp_width);
        h = longint'(vp_height);
        p = '0;
        if (cw >= TENTH) begin
            nx = sat32((cx * ONE) / cw);
            ny = sat32((cy * ONE) / cw);
            p.vis = 1'b1;
            p.sx = 32'(sat32((w * (ONE + nx)) >>> 1));
            p.sy = 32'(sat32((h * (ONE - ny)) >>> 1));
        end
        return p;
    endfunction

    assign pending = expected_pts.size();

    always @(posedge clk or negedge rst_n)
    begin
        screen_pt_t e;
        if (!rst_n)
        begin
            expected_pts.delete();
            vp_width <= WIDTH_RST;
            vp_height <= HEIGHT_RST;
            for (int i = 0; i < 16; i++)
                coef_mem[i] = '0;
            errors <= 0;
            n_loads <= 0;
            n_onscreen <= 0;
            n_offscreen <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_WIDTH)
                    vp_width <= pwdata[DIM_W-1:0];
                else if (paddr == ADDR_HEIGHT)
                    vp_height <= pwdata[DIM_W-1:0];
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pts.size() == 0)
                begin
                    $error("unexpected result: visible %0b x %0d y %0d",
                           visible, screen_x, screen_y);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_pts.pop_front();
                    if (visible !== e.vis || screen_x !== e.sx || screen_y !== e.sy)
                        errors <= errors + 1;
                    if (visible !== e.vis)
                        $error("visible: expected %0b got %0b", e.vis, visible);
                    if (screen_x !== e.sx)
                        $error("screen_x: expected %0d got %0d", e.sx, screen_x);
                    if (screen_y !== e.sy)
                        $error("screen_y: expected %0d got %0d", e.sy, screen_y);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (req_type == REQ_LOAD)
                begin
                    coef_mem[coef_index] = coef_value;
                    n_loads <= n_loads + 1;
                end
                else
                begin
                    e = project_point(pos_x, pos_y, pos_z);
                    expected_pts.push_back(e);
                    if (e.vis)
                        n_onscreen <= n_onscreen + 1;
                    else
                        n_offscreen <= n_offscreen + 1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Testbench top for world_to_screen_projection: clock, reset, APB viewport writes,
// bursty item stimulus and receiver stalls; verdict from wtsp_checker. Depends on wtsp_pkg.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import wtsp_pkg::*;

    localparam int Q1 = 65536;
    localparam int SETTLE = 80;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 req_type = REQ_LOAD;
    logic [IDX_W-1:0]     coef_index = '0;
    logic signed [31:0]   coef_value = '0;
    logic signed [31:0]   pos_x = '0;
    logic signed [31:0]   pos_y = '0;
    logic signed [31:0]   pos_z = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 visible;
    logic signed [31:0]   screen_x;
    logic signed [31:0]   screen_y;

    int errors, pending, n_loads, n_onscreen, n_offscreen;
    int burst_left = 0;
    int n_settings = 0;
    int stall_mode = 0;
    int stall_tick = 0;

    world_to_screen_projection dut (.*);

    wtsp_checker chk (.*);

    always #6 clk = ~clk;

    initial
    begin
        #20ms;
        $display("world_to_screen_projection regression: fail");
        $finish;
    end

    // receiver stall pattern: free run, light random, periodic blocks, or heavy random
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 300 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= ((stall_tick % 23) > 15);
            default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    task automatic apb_write(logic [ADDR_W-1:0] a, logic [31:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_item(logic rt, logic [3:0] idx, logic [31:0] cv,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req_type <= rt;
        coef_index <= idx;
        coef_value <= cv;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic load_coef(int idx, logic [31:0] v);
        push_item(REQ_LOAD, 4'(idx), v, $urandom, $urandom, $urandom);
    endtask

    task automatic project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        push_item(REQ_PROJECT, 4'($urandom), $urandom, x, y, z);
    endtask

    function automatic logic [31:0] small_val(int span);
        return 32'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
            default: return small_val(100 * Q1);
        endcase
    endfunction

    // a fresh 16-coefficient matrix: mostly well-formed with the w offset kept positive
    task automatic load_matrix();
        bit wild;
        logic [31:0] v;
        wild = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < 16; i++)
        begin
            if (wild)
                v = $urandom;
            else if (i == 15)
                v = 32'($urandom_range(Q1 / 8, 200 * Q1));
            else if (i == 3 || i == 7 || i == 11)
                v = small_val(Q1 / 64);
            else
                v = small_val(2 * Q1);
            load_coef(i, v);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_viewport(int w, int h);
        wait_idle();
        apb_write(ADDR_WIDTH, 32'(w));
        apb_write(ADDR_HEIGHT, 32'(h));
        n_settings++;
    endtask

    initial
    begin
        int vp_w [6] = '{640, 1, 8192, 16383, 0, 1920};
        int vp_h [6] = '{480, 1, 8192, 0, 16383, 1080};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity matrix, origin, axes, extremes, w threshold
        for (int i = 0; i < 16; i++)
            load_coef(i, (i % 5 == 0) ? Q1 : 0);
        project(0, 0, 0);
        project(Q1, 0, 0);
        project(-Q1, -Q1, 0);
        project(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        project(32'h80000000, 32'h7fffffff, 0);
        load_coef(15, 6553);
        project(0, 0, 0);
        load_coef(15, 6554);
        project(Q1 / 2, -Q1 / 2, 0);
        load_coef(15, 0);
        project(Q1, Q1, Q1);
        load_coef(15, 32'h80000000);
        project(Q1, Q1, Q1);
        load_coef(15, 32'h7fffffff);
        load_coef(0, 32'h7fffffff);
        project(32'h7fffffff, 32'h7fffffff, 0);

        // random: one phase per viewport setting
        for (int s = 0; s < 6; s++)
        begin
            set_viewport(vp_w[s], vp_h[s]);
            load_matrix();
            for (int n = 0; n < 125; n++)
            begin
                case ($urandom_range(0, 19))
                    0: load_matrix();
                    1: load_coef($urandom_range(0, 15), ($urandom_range(0, 1) != 0) ?
                                 $urandom : small_val(2 * Q1));
                    default: project(rand_coord(), rand_coord(), rand_coord());
                endcase
            end
        end

        wait_idle();
        $display("covered %0d coefficient loads and %0d projections (%0d on screen, %0d off)",
                 n_loads, n_onscreen + n_offscreen, n_onscreen, n_offscreen);
        $display("over %0d viewport settings including zero and maximum sizes", n_settings + 1);
        if (errors == 0 && pending == 0)
            $display("world_to_screen_projection regression: pass");
        else
            $display("world_to_screen_projection regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
rtl/core/wtsp_pkg.sv
rtl/core/world_to_screen_projection.sv
test/wtsp_checker.sv
test/tb_top.sv
